// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of the paddle keyer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IPK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IPK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ipk_pkg.sv -----
// Package for the iambic paddle keyer: types, register indexes and widths.
// No dependencies.
`default_nettype none

package ipk_pkg;

	localparam int TIME_W = 32;
	localparam int LEN_W  = 16;
	localparam int HOLD_W = LEN_W + 1;
	localparam int CMP_W  = (TIME_W > HOLD_W) ? TIME_W : HOLD_W;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_DOT_LENGTH     = 3'd0;
	localparam logic [IDX_W-1:0] REG_DASH_LENGTH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAP_LENGTH     = 3'd2;
	localparam logic [IDX_W-1:0] REG_SWAP_PADDLES   = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUT_ACTIVE_LOW = 3'd4;

	typedef enum logic [2:0] {
		MODE_OFF    = 3'd0,
		MODE_ON     = 3'd1,
		MODE_DOTS   = 3'd2,
		MODE_DASHES = 3'd3,
		MODE_INTER  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		EL_MANUAL = 2'd0,
		EL_DOT    = 2'd1,
		EL_DASH   = 2'd2,
		EL_NONE   = 2'd3
	} elem_t;

	typedef struct packed {
		logic [LEN_W-1:0] dot_length;
		logic [LEN_W-1:0] dash_length;
		logic [LEN_W-1:0] gap_length;
		logic             swap_paddles;
		logic             out_active_low;
	} cfg_t;

	typedef struct packed {
		logic              operation;
		logic [TIME_W-1:0] now;
		logic              straight_down;
		logic              left_down;
		logic              right_down;
	} item_t;

endpackage

`default_nettype wire

// ----- rtl/ipk_mode.sv -----
// Mode selection from the key and paddle levels, by priority.
// Depends on ipk_pkg.
`default_nettype none

module ipk_mode (
	input  wire logic           straight_down,
	input  wire logic           left_down,
	input  wire logic           right_down,
	input  wire logic           swap_paddles,
	output ipk_pkg::mode_t      mode
);
	import ipk_pkg::*;

	logic dot_p;
	logic dash_p;

	assign dot_p  = swap_paddles ? right_down : left_down;
	assign dash_p = swap_paddles ? left_down : right_down;

	always_comb begin
		priority if (straight_down) begin
			mode = MODE_ON;
		end else if (left_down && right_down) begin
			mode = MODE_INTER;
		end else if (dot_p) begin
			mode = MODE_DOTS;
		end else if (dash_p) begin
			mode = MODE_DASHES;
		end else begin
			mode = MODE_OFF;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ipk_core.sv -----
// Keyer state and its single-pass update for one beat.
// Depends on ipk_pkg and ipk_mode.
`default_nettype none

module ipk_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire ipk_pkg::item_t item,
	input  wire ipk_pkg::cfg_t  cfg,
	output logic                key_next,
	output ipk_pkg::mode_t      mode_next
);
	import ipk_pkg::*;

	logic              keyed_q, keyed_n;
	logic              panic_q, panic_n;
	mode_t             mode_q, mode_n;
	elem_t             last_q, last_n;
	logic [TIME_W-1:0] start_q, start_n;
	logic [HOLD_W-1:0] hold_q, hold_n;
	logic [HOLD_W-1:0] lock_q, lock_n;

	mode_t             sel_mode;
	logic              changed;
	logic              panic_eff;
	logic [TIME_W-1:0] el;
	logic [CMP_W-1:0]  el_x;
	logic              hold_past;
	logic              lock_past;
	elem_t             new_el;
	logic [HOLD_W-1:0] new_hold;

	ipk_mode u_mode (
		.straight_down (item.straight_down),
		.left_down     (item.left_down),
		.right_down    (item.right_down),
		.swap_paddles  (cfg.swap_paddles),
		.mode          (sel_mode)
	);

	assign changed   = (sel_mode != mode_q);
	assign panic_eff = panic_q && !changed;
	assign el        = item.now - start_q;
	assign el_x      = CMP_W'(el);
	assign hold_past = el_x > CMP_W'(hold_q);
	assign lock_past = el_x > CMP_W'(lock_q);

	always_comb begin
		unique case (sel_mode)
			MODE_DOTS:   new_el = EL_DOT;
			MODE_DASHES: new_el = EL_DASH;
			default:     new_el = (last_q == EL_DOT) ? EL_DASH : EL_DOT;
		endcase
		new_hold = (new_el == EL_DOT) ? HOLD_W'(cfg.dot_length) : HOLD_W'(cfg.dash_length);
	end

	// next state
	always_comb begin
		keyed_n = keyed_q;
		panic_n = panic_q;
		mode_n  = mode_q;
		last_n  = last_q;
		start_n = start_q;
		hold_n  = hold_q;
		lock_n  = lock_q;
		if (item.operation) begin
			panic_n = 1'b1;
			keyed_n = 1'b0;
		end else begin
			mode_n  = sel_mode;
			panic_n = panic_eff;
			unique case (sel_mode)
				MODE_OFF: begin
					if (keyed_q && (hold_q == '0 || hold_past)) begin
						keyed_n = 1'b0;
					end
					if (last_q != EL_NONE && (lock_q == '0 || lock_past)) begin
						last_n  = EL_NONE;
						start_n = '0;
						hold_n  = '0;
						lock_n  = '0;
					end
				end
				MODE_ON: begin
					if (!panic_eff && (changed || !keyed_q)) begin
						keyed_n = 1'b1;
						last_n  = EL_MANUAL;
						start_n = item.now;
						hold_n  = '0;
						lock_n  = '0;
					end
				end
				default: begin
					if (!panic_eff && (last_q == EL_NONE || lock_past) && !keyed_q) begin
						keyed_n = 1'b1;
						last_n  = new_el;
						start_n = item.now;
						hold_n  = new_hold;
						lock_n  = new_hold + HOLD_W'(cfg.gap_length);
					end else if (keyed_q && hold_past) begin
						keyed_n = 1'b0;
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		key_next  = keyed_n;
		mode_next = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyed_q <= 1'b0;
			panic_q <= 1'b0;
			mode_q  <= MODE_OFF;
			last_q  <= EL_NONE;
			start_q <= '0;
			hold_q  <= '0;
			lock_q  <= '0;
		end else if (step) begin
			keyed_q <= keyed_n;
			panic_q <= panic_n;
			mode_q  <= mode_n;
			last_q  <= last_n;
			start_q <= start_n;
			hold_q  <= hold_n;
			lock_q  <= lock_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iambic_paddle_keyer_unit.sv -----
// Top level of the iambic paddle keyer: register file, input and result stages.
// Depends on ipk_pkg and ipk_core.
`default_nettype none

// Takes one beat per clock while in_stall is low: a time tick with key levels, or a
// panic event. Each beat yields exactly one result beat (key state, pin level, mode),
// registered first in the input register and then in the result register, where it
// holds while out_stall is high. Throughput is one beat per cycle when the output
// side does not stall, set by the keyer state update, which is combinational between
// the input register and the result register. Write the configuration registers
// only while no beat is in flight.
module iambic_paddle_keyer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ipk_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [ipk_pkg::LEN_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        operation,
	input  wire logic [ipk_pkg::TIME_W-1:0]  now,
	input  wire logic                        straight_down,
	input  wire logic                        left_down,
	input  wire logic                        right_down,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             key_active,
	output logic                             pin_level,
	output logic [2:0]                       mode_now
);
	import ipk_pkg::*;

	cfg_t  cfg_q;
	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	logic  key_next;
	mode_t mode_next;
	logic  valid_s2;
	logic  key_s2;
	logic  pin_s2;
	mode_t mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DOT_LENGTH:     cfg_q.dot_length     <= cfg_data;
				REG_DASH_LENGTH:    cfg_q.dash_length    <= cfg_data;
				REG_GAP_LENGTH:     cfg_q.gap_length     <= cfg_data;
				REG_SWAP_PADDLES:   cfg_q.swap_paddles   <= cfg_data[0];
				REG_OUT_ACTIVE_LOW: cfg_q.out_active_low <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{operation: operation, now: now, straight_down: straight_down,
				left_down: left_down, right_down: right_down};
		end
	end

	ipk_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.item      (item_s1),
		.cfg       (cfg_q),
		.key_next  (key_next),
		.mode_next (mode_next)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			key_s2  <= key_next;
			pin_s2  <= key_next ^ cfg_q.out_active_low;
			mode_s2 <= mode_next;
		end
	end

	assign out_valid  = valid_s2;
	assign key_active = key_s2;
	assign pin_level  = pin_s2;
	assign mode_now   = mode_s2;

endmodule

`default_nettype wire

// ----- rtl/ipk_checker.sv -----
// Port-level checker for the paddle keyer, bound to the top level.
// Depends on ipk_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ipk_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ipk_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [ipk_pkg::LEN_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic                        key_active,
	input  wire logic                        pin_level,
	input  wire logic [2:0]                  mode_now
);
	import ipk_pkg::*;

	logic active_low_q;

	// track output polarity from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= 1'b0;
		end else if (cfg_we && cfg_index == REG_OUT_ACTIVE_LOW) begin
			active_low_q <= cfg_data[0];
		end
	end

	`IPK_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(key_active) && $stable(pin_level) && $stable(mode_now), "stalled result beat changed")
	`IPK_ASSERT_IMP(a_in_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a stalled result")
	`IPK_ASSERT_IMP(a_out_origin, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result beat without an input beat")
	`IPK_ASSERT_IMP(a_pin_polarity, clk, arst_n, out_valid, pin_level == (key_active ^ active_low_q), "pin level disagrees with polarity")

endmodule

bind iambic_paddle_keyer_unit ipk_checker u_ipk_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for iambic_paddle_keyer_unit: a directed table of ticks and panics,
// then random key sequences under several register settings, all checked beat by beat.
// Depends on ipk_pkg and the keyer RTL; needs no files or arguments.
module tb;
	import ipk_pkg::*;

	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 80;
	localparam int DIR_ROWS = 25;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_PANIC = 1'b1;

	typedef struct packed {
		logic  key_active;
		logic  pin_level;
		mode_t mode;
	} key_res_t;

	typedef struct packed {
		item_t    beat;
		logic     fixed;
		key_res_t want;
	} dir_row_t;

	localparam key_res_t NO_WANT = '{1'b0, 1'b0, MODE_OFF};

	// dot 2, dash 5, gap 1, paddles not swapped, active high
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{'{OP_TICK,  32'd0,          1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_OFF}},
		'{'{OP_TICK,  32'd10,         1'b1, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, MODE_ON}},
		'{'{OP_PANIC, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, MODE_ON}},
		'{'{OP_TICK,  32'd11,         1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, MODE_ON}},
		'{'{OP_TICK,  32'd12,         1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd13,         1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd15,         1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd16,         1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_PANIC, 32'd17,         1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd30,         1'b0, 1'b1, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd31,         1'b0, 1'b1, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd37,         1'b0, 1'b1, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd38,         1'b0, 1'b1, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd39,         1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd41,         1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd42,         1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd43,         1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd48,         1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd49,         1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'hFFFF_FFFE,  1'b1, 1'b0, 1'b0}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd3,          1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, MODE_OFF}},
		'{'{OP_TICK,  32'hFFFF_FFF0,  1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd1,          1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_TICK,  32'd2,          1'b0, 1'b0, 1'b1}, 1'b0, NO_WANT},
		'{'{OP_PANIC, 32'd0,          1'b0, 1'b0, 1'b0}, 1'b0, NO_WANT}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [LEN_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              operation;
	logic [TIME_W-1:0] now;
	logic              straight_down;
	logic              left_down;
	logic              right_down;
	logic              out_valid;
	logic              out_stall;
	logic              key_active;
	logic              pin_level;
	logic [2:0]        mode_now;

	// keyer state as seen from outside
	logic [LEN_W-1:0]  dot_len;
	logic [LEN_W-1:0]  dash_len;
	logic [LEN_W-1:0]  gap_len;
	logic              swap_pad;
	logic              act_low;
	logic              keyed;
	logic              panicked;
	mode_t             cur_mode;
	elem_t             last_el;
	logic [TIME_W-1:0] el_start;
	logic [HOLD_W-1:0] hold_len;
	logic [HOLD_W-1:0] lock_len;

	key_res_t    pending_keys[$];
	int          src_gap_pct;
	int          sink_stall_pct;
	bit          long_hold_req;
	int          fails = 0;
	int unsigned cycle_count = 0;

	iambic_paddle_keyer_unit i_dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("iambic_paddle_keyer_unit verification failed");
			$finish;
		end
	end

	function automatic mode_t pick_mode(logic s, logic l, logic r);
		if (s)
			return MODE_ON;
		if (l && r)
			return MODE_INTER;
		if (swap_pad ? r : l)
			return MODE_DOTS;
		if (swap_pad ? l : r)
			return MODE_DASHES;
		return MODE_OFF;
	endfunction

	function automatic key_res_t key_update(item_t b);
		mode_t             nxt;
		logic              moved;
		logic [TIME_W-1:0] span;
		elem_t             el;
		if (b.operation == OP_PANIC) begin
			panicked = 1'b1;
			keyed = 1'b0;
		end else begin
			nxt = pick_mode(b.straight_down, b.left_down, b.right_down);
			moved = (nxt != cur_mode);
			cur_mode = nxt;
			if (moved)
				panicked = 1'b0;
			span = b.now - el_start;
			case (cur_mode)
				MODE_OFF: begin
					if (keyed && (hold_len == '0 || span > TIME_W'(hold_len)))
						keyed = 1'b0;
					if (last_el != EL_NONE && (lock_len == '0 || span > TIME_W'(lock_len))) begin
						last_el = EL_NONE;
						el_start = '0;
						hold_len = '0;
						lock_len = '0;
					end
				end
				MODE_ON: begin
					if (!panicked && (moved || !keyed)) begin
						keyed = 1'b1;
						last_el = EL_MANUAL;
						el_start = b.now;
						hold_len = '0;
						lock_len = '0;
					end
				end
				default: begin
					if (!panicked && !keyed && (last_el == EL_NONE || span > TIME_W'(lock_len))) begin
						if (cur_mode == MODE_DOTS)
							el = EL_DOT;
						else if (cur_mode == MODE_DASHES)
							el = EL_DASH;
						else
							el = (last_el == EL_DOT) ? EL_DASH : EL_DOT;
						keyed = 1'b1;
						last_el = el;
						el_start = b.now;
						hold_len = (el == EL_DOT) ? HOLD_W'(dot_len) : HOLD_W'(dash_len);
						lock_len = hold_len + HOLD_W'(gap_len);
					end else if (keyed && span > TIME_W'(hold_len)) begin
						keyed = 1'b0;
					end
				end
			endcase
		end
		return '{keyed, keyed ^ act_low, cur_mode};
	endfunction

	task automatic load_settings(logic [LEN_W-1:0] dl, logic [LEN_W-1:0] dh,
			logic [LEN_W-1:0] gl, logic sw, logic al);
		cfg_we <= 1'b1;
		cfg_index <= REG_DOT_LENGTH;
		cfg_data <= dl;
		@(posedge clk);
		cfg_index <= REG_DASH_LENGTH;
		cfg_data <= dh;
		@(posedge clk);
		cfg_index <= REG_GAP_LENGTH;
		cfg_data <= gl;
		@(posedge clk);
		cfg_index <= REG_SWAP_PADDLES;
		cfg_data <= LEN_W'(sw);
		@(posedge clk);
		cfg_index <= REG_OUT_ACTIVE_LOW;
		cfg_data <= LEN_W'(al);
		@(posedge clk);
		cfg_we <= 1'b0;
		dot_len = dl;
		dash_len = dh;
		gap_len = gl;
		swap_pad = sw;
		act_low = al;
	endtask

	task automatic offer(item_t b, logic fixed, key_res_t want);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= b.operation;
		now <= b.now;
		straight_down <= b.straight_down;
		left_down <= b.left_down;
		right_down <= b.right_down;
		do
			@(posedge clk);
		while (in_stall);
		if (fixed) begin
			void'(key_update(b));
			pending_keys.push_back(want);
		end else begin
			pending_keys.push_back(key_update(b));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_keys.size() != 0);
	endtask

	initial begin : sink
		key_res_t want;
		int       hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_keys.size() == 0) begin
					$error("result beat with nothing pending");
					fails++;
				end else begin
					want = pending_keys.pop_front();
					if (key_active !== want.key_active) begin
						$error("key_active: expected %0d, got %0d", want.key_active, key_active);
						fails++;
					end
					if (pin_level !== want.pin_level) begin
						$error("pin_level: expected %0d, got %0d", want.pin_level, pin_level);
						fails++;
					end
					if (mode_now !== want.mode) begin
						$error("mode_now: expected %0d, got %0d", want.mode, mode_now);
						fails++;
					end
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
			end
		end
	end

	initial begin : source
		item_t            b;
		logic [2:0]       keys;
		logic [TIME_W-1:0] t_now;
		logic [LEN_W-1:0] dl;
		logic [LEN_W-1:0] dh;
		logic [LEN_W-1:0] gl;
		logic             sw;
		logic             al;
		int               step_max;
		int               pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DOT_LENGTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_TICK;
		now <= '0;
		straight_down <= 1'b0;
		left_down <= 1'b0;
		right_down <= 1'b0;
		long_hold_req = 1'b0;
		dot_len = '0;
		dash_len = '0;
		gap_len = '0;
		swap_pad = 1'b0;
		act_low = 1'b0;
		keyed = 1'b0;
		panicked = 1'b0;
		cur_mode = MODE_OFF;
		last_el = EL_NONE;
		el_start = '0;
		hold_len = '0;
		lock_len = '0;
		src_gap_pct = 35;
		sink_stall_pct = 54;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_settings(16'd2, 16'd5, 16'd1, 1'b0, 1'b0);
		for (int i = 0; i < DIR_ROWS; i++)
			offer(DIR_TABLE[i].beat, DIR_TABLE[i].fixed, DIR_TABLE[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph == 3) begin
				src_gap_pct = 54;
				sink_stall_pct = 35;
			end
			if (ph == 6) begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			case (ph)
				1: begin
					dl = '0;
					dh = '0;
					gl = '0;
					sw = 1'b0;
					al = 1'b0;
				end
				3: begin
					dl = '1;
					dh = '1;
					gl = '1;
					sw = 1'b1;
					al = 1'b1;
				end
				4: begin
					dl = LEN_W'($urandom_range(1, 2000));
					dh = LEN_W'($urandom_range(1, 2000));
					gl = LEN_W'($urandom_range(0, 2000));
					sw = 1'($urandom);
					al = 1'($urandom);
				end
				6: begin
					dl = LEN_W'($urandom);
					dh = LEN_W'($urandom);
					gl = LEN_W'($urandom);
					sw = 1'($urandom);
					al = 1'($urandom);
				end
				default: begin
					dl = LEN_W'($urandom_range(1, 8));
					dh = LEN_W'($urandom_range(2, 24));
					gl = LEN_W'($urandom_range(0, 6));
					sw = 1'($urandom);
					al = 1'($urandom);
				end
			endcase
			load_settings(dl, dh, gl, sw, al);
			step_max = (int'(dl > dh ? dl : dh) + int'(gl)) / 3 + 1;
			t_now = $urandom;
			keys = 3'b000;

			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (ph == 1 && n == 10)
					long_hold_req = 1'b1;
				if (ph == 4 && n == 40)
					drain();
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					b.operation = OP_PANIC;
					b.now = $urandom;
					{b.straight_down, b.left_down, b.right_down} = 3'($urandom);
				end else if (pick < 8) begin
					b.operation = OP_TICK;
					b.now = $urandom;
					{b.straight_down, b.left_down, b.right_down} = 3'($urandom);
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						pick = $urandom_range(0, 9);
						if (pick < 2)
							keys = 3'b000;
						else if (pick < 4)
							keys = 3'b010;
						else if (pick < 6)
							keys = 3'b001;
						else if (pick < 9)
							keys = 3'b011;
						else
							keys = {1'b1, 2'($urandom)};
					end
					t_now += TIME_W'($urandom_range(0, step_max));
					b.operation = OP_TICK;
					b.now = t_now;
					{b.straight_down, b.left_down, b.right_down} = keys;
				end
				offer(b, 1'b0, NO_WANT);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("iambic_paddle_keyer_unit verification clean");
		else
			$display("iambic_paddle_keyer_unit verification failed");
		$finish;
	end

endmodule
